@@ src/asc_pkg.sv @@
// Shared types and constants for the audio sync sample corrector.
package asc_pkg;

  localparam int TIME_W    = 48;
  localparam int DIFF_W    = 49;
  localparam int ACC_W     = 56;
  localparam int SAMPLES_W = 16;
  localparam int WANTED_W  = 17;
  localparam int MODE_W    = 2;
  localparam int COEF_W    = 16;
  localparam int THRESH_W  = 32;
  localparam int RATE_W    = 18;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  // Magnitude of a usable clock difference stays below ten seconds in Q.16.
  localparam int NOSYNC_LIMIT_Q16 = 655360;
  localparam int DMAG_W           = 20;
  localparam int DELTA_W          = 22;

  // Division by ten as a multiply by a rounded-up reciprocal, exact below 2^23 / 6.
  localparam int RECIP_TEN    = 838861;
  localparam int RECIP_SHIFT  = 23;
  localparam int LIMIT_LO_NUM = 9;
  localparam int LIMIT_HI_NUM = 11;

  localparam logic [MODE_W-1:0]   SYNC_MODE_RESET     = 2'd0;
  localparam logic                VIDEO_PRESENT_RESET = 1'b1;
  localparam logic                AUDIO_PRESENT_RESET = 1'b1;
  localparam logic [COEF_W-1:0]   AVG_COEF_RESET      = 16'd58412;
  localparam logic [THRESH_W-1:0] THRESHOLD_RESET     = 32'd3041;
  localparam logic [RATE_W-1:0]   SOURCE_RATE_RESET   = 18'd44100;

  typedef enum logic [2:0] {
    REG_SYNC_MODE     = 3'd0,
    REG_VIDEO_PRESENT = 3'd1,
    REG_AUDIO_PRESENT = 3'd2,
    REG_AVG_COEF      = 3'd3,
    REG_THRESHOLD     = 3'd4,
    REG_SOURCE_RATE   = 3'd5
  } reg_index_t;

  typedef enum logic [MODE_W-1:0] {
    SYNC_AUDIO    = 2'd0,
    SYNC_VIDEO    = 2'd1,
    SYNC_EXTERNAL = 2'd2
  } sync_mode_t;

  typedef struct packed {
    logic [MODE_W-1:0]   sync_mode;
    logic                video_present;
    logic                audio_present;
    logic [COEF_W-1:0]   average_coefficient;
    logic [THRESH_W-1:0] correction_threshold;
    logic [RATE_W-1:0]   source_rate;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_CHECK,
    ST_PMUL,
    ST_PADD,
    ST_SUM,
    ST_AMAG,
    ST_AMUL,
    ST_AVG,
    ST_CLIP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic diff;
    logic check;
    logic clear;
    logic mul;
    logic mul_avg;
    logic padd;
    logic sum;
    logic amag;
    logic avg;
    logic clip;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic audio_master;
    logic diff_ok;
    logic warm_done;
    logic avg_reached;
    logic out_free;
  } dp_status_t;

endpackage

@@ src/asc_in_if.sv @@
// Request channel carrying one audio frame's clocks and sample count.
interface asc_in_if import asc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [TIME_W-1:0]   audio_time;
  logic                       audio_time_valid;
  logic signed [TIME_W-1:0]   master_time;
  logic                       master_time_valid;
  logic [SAMPLES_W-1:0]       frame_samples;

  modport source (
    output valid, audio_time, audio_time_valid, master_time, master_time_valid,
    frame_samples,
    input  ready
  );
  modport sink (
    input  valid, audio_time, audio_time_valid, master_time, master_time_valid,
    frame_samples,
    output ready
  );
endinterface

@@ src/asc_out_if.sv @@
// Request channel carrying the corrected sample count of one frame.
interface asc_out_if import asc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WANTED_W-1:0] wanted_samples;
  logic                corrected;

  modport source (output valid, wanted_samples, corrected, input ready);
  modport sink (input valid, wanted_samples, corrected, output ready);
endinterface

@@ src/audio_sync_sample_corrector.sv @@
// Audio sync sample corrector: turns each audio frame's sample count into a
// drift-corrected count. One frame request is taken at a time. A frame whose
// effective master is the audio clock, or whose clock difference is invalid
// or ten seconds or more, goes from the difference check straight to output;
// a frame still in warm-up leaves after the accumulator update, and a frame
// that reaches the threshold test is clipped only if the averaged magnitude
// reaches it; the block is then ready again. The controller walks the
// datapath: a subtract, a magnitude, a shared 40x17 scaling multiplier used
// once for the averaging filter and once for the averaged magnitude, the
// accumulator update with saturation, and the final clip. The result sits in
// an output register, so a new frame is accepted while the previous result is
// still waiting to be taken; the block only stalls in its last step if that
// register is still full. The difference accumulator and warm-up count live in
// the datapath; reset or an unusable non-audio-master difference clears them.
// Configuration goes through the APB-style port, one 32-bit register every
// four bytes: sync mode, video present, audio present, averaging
// coefficient, correction threshold and source rate. Writes are not blocked
// by the block, so they must be made only while no frame is in flight.
module audio_sync_sample_corrector import asc_pkg::*; #(
  parameter int WARMUP_FRAMES = 20
) (
  input  logic              clk,
  input  logic              rst,
  asc_in_if.sink            frame,
  asc_out_if.source         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;

  // Register file for the six configuration settings.
  asc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The controller accepts a request only when it is idle and sequences the
  // datapath from there.
  asc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (frame.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the working registers, the accumulator state and the
  // output register.
  asc_dp #(
    .WARMUP_FRAMES (WARMUP_FRAMES)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .status               (status),
    .cfg                  (cfg),
    .in_audio_time        (frame.audio_time),
    .in_audio_time_valid  (frame.audio_time_valid),
    .in_master_time       (frame.master_time),
    .in_master_time_valid (frame.master_time_valid),
    .in_frame_samples     (frame.frame_samples),
    .out_valid            (out_valid),
    .out_ready            (result.ready),
    .out_wanted_samples   (result.wanted_samples),
    .out_corrected        (result.corrected)
  );

  assign frame.ready  = in_ready;
  assign result.valid = out_valid;

endmodule

@@ src/asc_regs.sv @@
// APB-style configuration register file.
module asc_regs import asc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_mode            <= SYNC_MODE_RESET;
      cfg.video_present        <= VIDEO_PRESENT_RESET;
      cfg.audio_present        <= AUDIO_PRESENT_RESET;
      cfg.average_coefficient  <= AVG_COEF_RESET;
      cfg.correction_threshold <= THRESHOLD_RESET;
      cfg.source_rate          <= SOURCE_RATE_RESET;
    end else if (wr_en) begin
      case (paddr[ADDR_W-1:2])
        REG_SYNC_MODE:     cfg.sync_mode            <= pwdata[MODE_W-1:0];
        REG_VIDEO_PRESENT: cfg.video_present        <= pwdata[0];
        REG_AUDIO_PRESENT: cfg.audio_present        <= pwdata[0];
        REG_AVG_COEF:      cfg.average_coefficient  <= pwdata[COEF_W-1:0];
        REG_THRESHOLD:     cfg.correction_threshold <= pwdata[THRESH_W-1:0];
        REG_SOURCE_RATE:   cfg.source_rate          <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_SYNC_MODE:     prdata = DATA_W'(cfg.sync_mode);
      REG_VIDEO_PRESENT: prdata = DATA_W'(cfg.video_present);
      REG_AUDIO_PRESENT: prdata = DATA_W'(cfg.audio_present);
      REG_AVG_COEF:      prdata = DATA_W'(cfg.average_coefficient);
      REG_THRESHOLD:     prdata = DATA_W'(cfg.correction_threshold);
      REG_SOURCE_RATE:   prdata = DATA_W'(cfg.source_rate);
      default:           prdata = '0;
    endcase
  end

endmodule

@@ src/asc_ctrl.sv @@
// Sequencer that steps the datapath through one frame's correction.
module asc_ctrl import asc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (status.audio_master) begin
          state_next = ST_EMIT;
        end else if (!status.diff_ok) begin
          cmd.clear  = 1'b1;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_PMUL;
        end
      end
      ST_PMUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_PADD;
      end
      ST_PADD: begin
        cmd.padd   = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = status.warm_done ? ST_AMAG : ST_EMIT;
      end
      ST_AMAG: begin
        cmd.amag   = 1'b1;
        state_next = ST_AMUL;
      end
      ST_AMUL: begin
        cmd.mul     = 1'b1;
        cmd.mul_avg = 1'b1;
        state_next  = ST_AVG;
      end
      ST_AVG: begin
        cmd.avg    = 1'b1;
        state_next = status.avg_reached ? ST_CLIP : ST_EMIT;
      end
      ST_CLIP: begin
        cmd.clip   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ src/asc_dp.sv @@
// Datapath: difference, averaging accumulator, threshold test and clipped correction.
module asc_dp import asc_pkg::*; #(
  parameter int WARMUP_FRAMES = 20
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  input  cfg_t                     cfg,
  input  logic signed [TIME_W-1:0] in_audio_time,
  input  logic                     in_audio_time_valid,
  input  logic signed [TIME_W-1:0] in_master_time,
  input  logic                     in_master_time_valid,
  input  logic [SAMPLES_W-1:0]     in_frame_samples,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [WANTED_W-1:0]      out_wanted_samples,
  output logic                     out_corrected
);

  localparam int                WarmW    = $clog2(WARMUP_FRAMES + 1);
  localparam logic [WarmW-1:0]  WarmLast = WarmW'(WARMUP_FRAMES);
  localparam int                MulW     = ACC_W + 1;
  localparam int                LoW      = SAMPLES_W + 17;
  localparam int                ProdW    = DMAG_W + RATE_W;
  localparam int                LimXW    = 20;
  localparam int                LimQW    = 40;
  localparam logic signed [DIFF_W-1:0] LimPos = DIFF_W'(NOSYNC_LIMIT_Q16);
  localparam logic signed [DIFF_W-1:0] LimNeg = -LimPos;

  logic signed [TIME_W-1:0] audio_time;
  logic signed [TIME_W-1:0] master_time;
  logic                     times_valid;
  logic [SAMPLES_W-1:0]     frame_samples;
  logic signed [DIFF_W-1:0] diff;
  logic [DMAG_W-1:0]        diff_mag;
  logic signed [ACC_W-1:0]  acc;
  logic [WarmW-1:0]         warm;
  logic [ACC_W-1:0]         mag;
  logic [MulW-1:0]          prod_hi;
  logic [LoW-1:0]           prod_lo;
  logic [MulW-1:0]          psum;
  logic [ProdW-1:0]         delta_prod;
  logic [WANTED_W-1:0]      lim_lo;
  logic [WANTED_W-1:0]      lim_hi;
  logic [WANTED_W-1:0]      wanted_fix;
  logic                     corr;

  logic [16:0]              factor;
  logic [MulW-1:0]          mul_hi;
  logic [LoW-1:0]           mul_lo;
  logic [DIFF_W-1:0]        diff_abs;
  logic [ACC_W-1:0]         acc_abs;
  logic signed [57:0]       diff_ext;
  logic signed [57:0]       p_ext;
  logic signed [57:0]       sum_full;
  logic signed [ACC_W-1:0]  sum_sat;
  logic [MulW-1:0]          avg_val;
  logic [LimXW-1:0]         lo_x;
  logic [LimXW-1:0]         hi_x;
  logic [LimQW-1:0]         lo_q;
  logic [LimQW-1:0]         hi_q;
  logic [DELTA_W-1:0]       delta;
  logic signed [23:0]       n_ext;
  logic signed [23:0]       d_ext;
  logic signed [23:0]       w;
  logic signed [23:0]       lo_ext;
  logic signed [23:0]       hi_ext;
  logic [WANTED_W-1:0]      w_clip;
  logic                     audio_master;

  // Shared Q1.16 scaler: high and low halves of the magnitude times the factor.
  assign factor = cmd.mul_avg ? (17'h10000 - {1'b0, cfg.average_coefficient})
                              : {1'b0, cfg.average_coefficient};
  assign mul_hi = MulW'(mag[ACC_W-1:16]) * MulW'(factor);
  assign mul_lo = LoW'(mag[15:0]) * LoW'(factor);

  assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign acc_abs  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);

  assign diff_ext = {{(58 - DIFF_W){diff[DIFF_W-1]}}, diff};
  assign p_ext    = {1'b0, psum};
  assign sum_full = diff_ext + (acc[ACC_W-1] ? -p_ext : p_ext);

  always_comb begin
    if (sum_full[57:55] == 3'b000 || sum_full[57:55] == 3'b111) begin
      sum_sat = sum_full[ACC_W-1:0];
    end else if (sum_full[57]) begin
      sum_sat = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  assign avg_val = prod_hi + MulW'(prod_lo[LoW-1:16]);

  // Clip limits: floor(9n/10) and floor(11n/10).
  assign lo_x = LimXW'(frame_samples) * LimXW'(LIMIT_LO_NUM);
  assign hi_x = LimXW'(frame_samples) * LimXW'(LIMIT_HI_NUM);
  assign lo_q = LimQW'(lo_x) * LimQW'(RECIP_TEN);
  assign hi_q = LimQW'(hi_x) * LimQW'(RECIP_TEN);

  assign delta  = delta_prod[ProdW-1:16];
  assign n_ext  = {8'b0, frame_samples};
  assign d_ext  = {2'b0, delta};
  assign w      = diff[DIFF_W-1] ? (n_ext - d_ext) : (n_ext + d_ext);
  assign lo_ext = {7'b0, lim_lo};
  assign hi_ext = {7'b0, lim_hi};

  always_comb begin
    if (w < lo_ext) begin
      w_clip = lim_lo;
    end else if (w > hi_ext) begin
      w_clip = lim_hi;
    end else begin
      w_clip = w[WANTED_W-1:0];
    end
  end

  always_comb begin
    case (cfg.sync_mode)
      SYNC_VIDEO: audio_master = !cfg.video_present;
      SYNC_AUDIO: audio_master = cfg.audio_present;
      default:    audio_master = 1'b0;
    endcase
  end

  assign status.audio_master = audio_master;
  assign status.diff_ok      = times_valid && (diff < LimPos) && (diff > LimNeg);
  assign status.warm_done    = warm >= WarmLast;
  assign status.avg_reached  = avg_val >= MulW'(cfg.correction_threshold);
  assign status.out_free     = !out_valid || out_ready;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      warm      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        acc  <= '0;
        warm <= '0;
      end else if (cmd.sum) begin
        acc <= sum_sat;
        if (!status.warm_done) begin
          warm <= warm + 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      audio_time    <= in_audio_time;
      master_time   <= in_master_time;
      times_valid   <= in_audio_time_valid && in_master_time_valid;
      frame_samples <= in_frame_samples;
      corr          <= 1'b0;
    end
    if (cmd.diff) begin
      diff <= DIFF_W'(audio_time) - DIFF_W'(master_time);
    end
    if (cmd.check) begin
      diff_mag <= diff_abs[DMAG_W-1:0];
      mag      <= acc_abs;
    end
    if (cmd.amag) begin
      mag <= acc_abs;
    end
    if (cmd.mul) begin
      prod_hi <= mul_hi;
      prod_lo <= mul_lo;
    end
    if (cmd.mul && cmd.mul_avg) begin
      delta_prod <= ProdW'(diff_mag) * ProdW'(cfg.source_rate);
      lim_lo     <= lo_q[RECIP_SHIFT +: WANTED_W];
    end
    if (cmd.padd) begin
      psum <= prod_hi + MulW'(prod_lo[LoW-1:16]);
    end
    if (cmd.avg) begin
      lim_hi <= hi_q[RECIP_SHIFT +: WANTED_W];
    end
    if (cmd.clip) begin
      wanted_fix <= w_clip;
      corr       <= 1'b1;
    end
    if (cmd.emit) begin
      out_wanted_samples <= corr ? wanted_fix : {1'b0, frame_samples};
      out_corrected      <= corr;
    end
  end

endmodule
